>>> src/rle_pkg.sv
// ----------------------------------------------------------------------------
// rle_pkg
// Shared types and constants for the escape-byte run-length stream decoder.
// ----------------------------------------------------------------------------
package rle_pkg;

    // Output group geometry and header layout
    localparam int unsigned LANES     = 8;
    localparam int unsigned HDR_LEN   = 8;
    localparam int unsigned MAGIC_LEN = 4;

    localparam logic [2:0] HDR_LAST_POS = 3'(HDR_LEN - 1);
    localparam logic [3:0] LANES_CNT    = 4'(LANES);
    localparam logic [7:0] LANES_BYTE   = 8'(LANES);

    // Configuration register reset values
    localparam logic [7:0] RUN_ESC_RST = 8'hFF;
    localparam logic [7:0] LIT_ESC_RST = 8'hFE;

    // Configuration register indexes
    localparam logic [7:0] CFG_IDX_RUN_ESC = 8'd0;
    localparam logic [7:0] CFG_IDX_LIT_ESC = 8'd1;

    // File status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_MAGIC = 2'd2
    } t_status;

    // Decoder phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_IDLE,
        PH_RUN_COUNT,
        PH_RUN_VALUE,
        PH_LIT_COUNT,
        PH_LIT_DATA,
        PH_DISCARD,
        PH_EXPAND
    } t_phase;

    // Byte count selection for an output group
    typedef enum logic [1:0] {
        NS_ZERO,
        NS_ONE,
        NS_RUN
    } t_nsel;

    // Controller to datapath commands
    typedef struct packed {
        logic      out_load;
        t_nsel     nsel;
        logic      src_saved;
        logic      glast;
        logic      fend;
        t_status   status;
        logic      count_load;
        logic      count_dec;
        logic      count_sub;
        logic      save_val;
        logic [1:0] magic_idx;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic run_hit;
        logic lit_hit;
        logic in_zero;
        logic magic_eq;
        logic count_zero;
        logic count_one;
        logic count_gt;
    } t_dp_stat;

    // Header magic "RLEF"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h52;
            2'd1:    b = 8'h4C;
            2'd2:    b = 8'h45;
            default: b = 8'h46;
        endcase
        return b;
    endfunction

endpackage

>>> src/rle_in_if.sv
// ----------------------------------------------------------------------------
// rle_in_if
// Compressed byte input channel: one file byte and an end-of-file flag.
// ----------------------------------------------------------------------------
interface rle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> src/rle_out_if.sv
// ----------------------------------------------------------------------------
// rle_out_if
// Decoded output channel: a group of up to eight bytes plus framing/status.
// ----------------------------------------------------------------------------
interface rle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte0;
    logic [7:0] out_byte1;
    logic [7:0] out_byte2;
    logic [7:0] out_byte3;
    logic [7:0] out_byte4;
    logic [7:0] out_byte5;
    logic [7:0] out_byte6;
    logic [7:0] out_byte7;
    logic [3:0] valid_bytes;
    logic       group_last;
    logic       file_end;
    logic [1:0] status;

    modport source (
        output valid, output out_byte0, output out_byte1, output out_byte2,
        output out_byte3, output out_byte4, output out_byte5, output out_byte6,
        output out_byte7, output valid_bytes, output group_last, output file_end,
        output status, input ready
    );
    modport sink (
        input valid, input out_byte0, input out_byte1, input out_byte2,
        input out_byte3, input out_byte4, input out_byte5, input out_byte6,
        input out_byte7, input valid_bytes, input group_last, input file_end,
        input status, output ready
    );
endinterface

>>> src/rle_cfg_if.sv
// ----------------------------------------------------------------------------
// rle_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rle_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/rle_dp.sv
// ----------------------------------------------------------------------------
// rle_dp
// Datapath: escape registers, pending count, saved run byte and the output
// group register with its handshake.
// ----------------------------------------------------------------------------
module rle_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_in_byte,
    input  rle_pkg::t_dp_cmd   i_cmd,
    output rle_pkg::t_dp_stat  o_st,
    rle_cfg_if.sink            i_cfg,
    rle_out_if.source          o_out
);
    import rle_pkg::*;

    logic [7:0] r_run_esc;
    logic [7:0] r_lit_esc;
    logic [7:0] r_pending;
    logic [7:0] n_pending;
    logic [7:0] r_run_val;
    logic       r_out_valid;
    logic [7:0] r_lane [LANES];
    logic [3:0] r_nbytes;
    logic       r_glast;
    logic       r_fend;
    logic [1:0] r_status;
    logic [7:0] grp_val;
    logic [3:0] grp_n;

    // Configuration writes, always accepted
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_esc <= RUN_ESC_RST;
            r_lit_esc <= LIT_ESC_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_IDX_RUN_ESC) r_run_esc <= i_cfg.data;
            if (i_cfg.index == CFG_IDX_LIT_ESC) r_lit_esc <= i_cfg.data;
        end
    end

    // Pending count and saved run byte
    always_comb begin
        n_pending = r_pending;
        if (i_cmd.count_load)     n_pending = i_in_byte;
        else if (i_cmd.count_dec) n_pending = r_pending - 8'd1;
        else if (i_cmd.count_sub) n_pending = r_pending - LANES_BYTE;
    end

    always_ff @(posedge i_clk) begin
        r_pending <= n_pending;
        if (i_cmd.save_val) r_run_val <= i_in_byte;
    end

    // Status toward the controller
    assign o_st.out_free   = !r_out_valid || o_out.ready;
    assign o_st.run_hit    = (i_in_byte == r_run_esc);
    assign o_st.lit_hit    = (i_in_byte == r_lit_esc);
    assign o_st.in_zero    = (i_in_byte == 8'd0);
    assign o_st.magic_eq   = (i_in_byte == magic_byte(i_cmd.magic_idx));
    assign o_st.count_zero = (r_pending == 8'd0);
    assign o_st.count_one  = (r_pending == 8'd1);
    assign o_st.count_gt   = (r_pending > LANES_BYTE);

    // Group value and byte count
    assign grp_val = i_cmd.src_saved ? r_run_val : i_in_byte;

    always_comb begin
        case (i_cmd.nsel)
            NS_ZERO: grp_n = 4'd0;
            NS_ONE:  grp_n = 4'd1;
            NS_RUN:  grp_n = (r_pending > LANES_BYTE) ? LANES_CNT : r_pending[3:0];
            default: grp_n = 4'd0;
        endcase
    end

    // Output group register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            for (int j = 0; j < LANES; j++) begin
                r_lane[j] <= (4'(j) < grp_n) ? grp_val : 8'd0;
            end
            r_nbytes <= grp_n;
            r_glast  <= i_cmd.glast;
            r_fend   <= i_cmd.fend;
            r_status <= i_cmd.status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte0   = r_lane[0];
    assign o_out.out_byte1   = r_lane[1];
    assign o_out.out_byte2   = r_lane[2];
    assign o_out.out_byte3   = r_lane[3];
    assign o_out.out_byte4   = r_lane[4];
    assign o_out.out_byte5   = r_lane[5];
    assign o_out.out_byte6   = r_lane[6];
    assign o_out.out_byte7   = r_lane[7];
    assign o_out.valid_bytes = r_nbytes;
    assign o_out.group_last  = r_glast;
    assign o_out.file_end    = r_fend;
    assign o_out.status      = r_status;

endmodule

>>> src/rle_ctrl.sv
// ----------------------------------------------------------------------------
// rle_ctrl
// Controller: header check, record phases and run expansion sequencing.
// ----------------------------------------------------------------------------
module rle_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    input  rle_pkg::t_dp_stat  i_st,
    output rle_pkg::t_dp_cmd   o_cmd
);
    import rle_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [2:0] r_hpos;
    logic [2:0] n_hpos;
    logic       r_mm;
    logic       n_mm;
    logic       r_run_last;
    logic       n_run_last;
    logic       acc;
    logic       mm_now;
    logic       run_defer;
    logic       emit;
    t_status    step_status;

    assign o_in_ready = (r_phase != PH_EXPAND) && i_st.out_free;
    assign acc        = i_in_valid && o_in_ready;

    // Magic mismatch including the current header byte
    assign mm_now    = r_mm || (!r_hpos[2] && !i_st.magic_eq);
    // Long run: closing group comes later from the expansion state
    assign run_defer = (r_phase == PH_RUN_VALUE) && i_st.count_gt;

    // Next state
    always_comb begin
        n_phase    = r_phase;
        n_hpos     = r_hpos;
        n_mm       = r_mm;
        n_run_last = r_run_last;
        if (acc) begin
            case (r_phase)
                PH_HEADER: begin
                    n_mm = mm_now;
                    if (r_hpos == HDR_LAST_POS) begin
                        n_phase = mm_now ? PH_DISCARD : PH_IDLE;
                        n_hpos  = 3'd0;
                    end else begin
                        n_hpos = r_hpos + 3'd1;
                    end
                end
                PH_IDLE: begin
                    if (i_st.run_hit)      n_phase = PH_RUN_COUNT;
                    else if (i_st.lit_hit) n_phase = PH_LIT_COUNT;
                end
                PH_RUN_COUNT: n_phase = PH_RUN_VALUE;
                PH_RUN_VALUE: begin
                    if (i_st.count_gt) begin
                        n_phase    = PH_EXPAND;
                        n_run_last = i_in_last;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_LIT_COUNT: n_phase = i_st.in_zero ? PH_IDLE : PH_LIT_DATA;
                PH_LIT_DATA: begin
                    if (i_st.count_one) n_phase = PH_IDLE;
                end
                PH_DISCARD: n_phase = PH_DISCARD;
                default:    n_phase = PH_IDLE;
            endcase
            // End of file returns to the header phase
            if (i_in_last && !run_defer) begin
                n_phase = PH_HEADER;
                n_hpos  = 3'd0;
                n_mm    = 1'b0;
            end
        end else if (r_phase == PH_EXPAND && i_st.out_free && !i_st.count_gt) begin
            n_phase = r_run_last ? PH_HEADER : PH_IDLE;
        end
    end

    // Datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.nsel      = NS_ONE;
        o_cmd.status    = ST_OK;
        o_cmd.magic_idx = r_hpos[1:0];
        emit            = 1'b0;
        step_status     = ST_OK;
        if (acc) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hpos == HDR_LAST_POS) begin
                        step_status = mm_now ? ST_BAD_MAGIC : ST_OK;
                    end else begin
                        step_status = ST_SHORT;
                    end
                end
                PH_IDLE: begin
                    emit = !i_st.run_hit && !i_st.lit_hit;
                end
                PH_RUN_COUNT: o_cmd.count_load = 1'b1;
                PH_RUN_VALUE: begin
                    emit       = !i_st.count_zero;
                    o_cmd.nsel = NS_RUN;
                    if (i_st.count_gt) begin
                        o_cmd.save_val  = 1'b1;
                        o_cmd.count_sub = 1'b1;
                    end
                end
                PH_LIT_COUNT: o_cmd.count_load = 1'b1;
                PH_LIT_DATA: begin
                    emit            = 1'b1;
                    o_cmd.count_dec = 1'b1;
                end
                PH_DISCARD: step_status = ST_BAD_MAGIC;
                default:    emit = 1'b0;
            endcase
            o_cmd.out_load = emit || (i_in_last && !run_defer);
            o_cmd.glast    = !run_defer;
            if (i_in_last && !run_defer) begin
                o_cmd.fend   = 1'b1;
                o_cmd.status = step_status;
                if (!emit) o_cmd.nsel = NS_ZERO;
            end
        end else if (r_phase == PH_EXPAND && i_st.out_free) begin
            // Drain the rest of a long run from the saved byte
            o_cmd.out_load  = 1'b1;
            o_cmd.nsel      = NS_RUN;
            o_cmd.src_saved = 1'b1;
            o_cmd.glast     = !i_st.count_gt;
            o_cmd.fend      = !i_st.count_gt && r_run_last;
            o_cmd.count_sub = i_st.count_gt;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hpos     <= 3'd0;
            r_mm       <= 1'b0;
            r_run_last <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hpos     <= n_hpos;
            r_mm       <= n_mm;
            r_run_last <= n_run_last;
        end
    end

`ifndef ASSERT_OFF
    // A group is only loaded when the output register can take it
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_st.out_free)
        else $error("output group loaded while output register busy");

    // The file-closing group always ends its input byte
    a_fend_glast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && o_cmd.fend) |-> o_cmd.glast)
        else $error("file end without group last");

    // Header position only advances inside the header
    a_hpos_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_HEADER) |-> (r_hpos == 3'd0))
        else $error("header position outside header phase");

    // A closed file leaves phase, header position and magic mismatch at reset values
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_in_last && !run_defer)
            |=> (r_phase == PH_HEADER && r_hpos == 3'd0 && !r_mm))
        else $error("state not cleared after last byte");

    // Expansion ends on the closing group of a run
    a_expand_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_EXPAND && o_cmd.out_load && o_cmd.glast)
            |=> (r_phase == PH_IDLE || r_phase == PH_HEADER))
        else $error("expansion did not finish after closing group");
`endif

endmodule

>>> src/rle_escape_stream_decoder.sv
// ----------------------------------------------------------------------------
// rle_escape_stream_decoder
// Escape-byte run-length decoder for an "RLEF" file stream.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : compressed file bytes, in_last set on the final byte. The first
//            8 bytes are the header (magic "RLEF" plus 4 ignored size bytes).
//   i_cfg  : register 0 = run escape (reset 0xFF), 1 = literal escape
//            (reset 0xFE). Write only while the decoder is idle.
//   o_out  : decoded groups of up to 8 bytes; valid_bytes gives the lanes
//            used, group_last ends the groups of one input byte, file_end
//            with status (ok / short / bad magic) closes the file.
// Registering: a result is loaded into the output register in the cycle after its input
//   request is accepted.
// Throughput: one input byte per cycle for header, literal and pass-through
//   bytes while the output is not stalled. A run of n bytes fills ceil(n/8)
//   output groups; input is held off while the run expander drains them.
// Stalls: a single output register; when the receiver stalls, input is held
//   off until the pending group is taken.
// Reset: decoder returns to the header phase, escapes take their reset
//   values, the output register empties. No clearing pass is needed.
// ----------------------------------------------------------------------------
module rle_escape_stream_decoder (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rle_in_if.sink   i_in,
    rle_cfg_if.sink  i_cfg,
    rle_out_if.source o_out
);
    import rle_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat st;
    logic     in_ready;

    assign i_in.ready = in_ready;

    rle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.in_last),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    rle_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_byte (i_in.in_byte),
        .i_cmd     (cmd),
        .o_st      (st),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape-byte run-length stream decoder. Files are
// fed one byte per request: first a short directed set (short file, bad magic,
// runs, literals, extremes), then random files under several escape settings.
// A local decoder model predicts each untyped group, and the monitor compares
// each accepted group field by field. Both sides idle at random, the receiver
// stalls once for a long stretch, and the sender drains between settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rle_pkg::*;

    localparam int unsigned MAX_GROUPS    = 32;
    localparam int unsigned LONG_HOLD     = 80;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned NUM_SETTINGS  = 6;
    localparam int unsigned SETTING_ITEMS = 30;
    localparam int unsigned DIR_ROWS      = 30;

    localparam logic [7:0] MAGIC_RLEF [4] = '{8'h52, 8'h4C, 8'h45, 8'h46};

    // One decoded output group
    typedef struct packed {
        logic [7:0][7:0] lane;
        logic [3:0]      nbytes;
        logic            glast;
        logic            fend;
        t_status         status;
    } t_group;

    // Directed row: a file byte, plus a typed-in expectation where it is obvious
    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        logic [3:0] nbytes;
        logic [7:0] value;
        t_status    status;
    } t_vec;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rle_in_if  in_ch ();
    rle_cfg_if cfg_ch ();
    rle_out_if out_ch ();

    rle_escape_stream_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Decoder model state and escape copies
    logic [7:0] run_esc;
    logic [7:0] lit_esc;
    t_phase     dec_phase;
    logic [3:0] hdr_pos;
    logic       magic_bad;
    logic [7:0] pend_cnt;

    t_group     step_q[$];
    t_group     exp_q[$];
    logic [7:0] file_q[$];

    int unsigned err_cnt   = 0;
    int unsigned n_bytes   = 0;
    int unsigned n_groups  = 0;
    int unsigned n_files   = 0;
    int unsigned n_cfg     = 0;
    bit          no_idle   = 1'b0;
    bit          hold_req  = 1'b0;

    // Directed files: short, bad magic, then a good file with records
    t_vec dir_tab [DIR_ROWS] = '{
        '{8'h52, 1'b1, 1'b1, 4'd0, 8'h00, ST_SHORT},
        '{8'h00, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h45, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h46, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h00, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h00, 1'b1, 1'b1, 4'd0, 8'h00, ST_BAD_MAGIC},
        '{8'h52, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h4C, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h45, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h46, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h00, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h00, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h00, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hAA, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h00, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h55, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFE, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h00, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFE, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h02, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 4'd0, 8'h00, ST_OK},
        '{8'h80, 1'b1, 1'b1, 4'd1, 8'h80, ST_OK}
    };

    // Group of n copies of a byte, unused lanes zero
    function automatic t_group make_group(input logic [7:0] value, input logic [3:0] n);
        t_group g;
        g = '0;
        for (int j = 0; j < LANES; j++)
            if (j < n) g.lane[j] = value;
        g.nbytes = n;
        return g;
    endfunction

    function automatic void clear_decoder();
        dec_phase = PH_HEADER;
        hdr_pos   = 4'd0;
        magic_bad = 1'b0;
        pend_cnt  = 8'd0;
    endfunction

    // Decoder model: groups caused by one file byte go to step_q
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        t_status     st;
        int unsigned remain;
        int unsigned g;
        t_group      tail;
        st = ST_OK;
        step_q.delete();
        case (dec_phase)
            PH_HEADER: begin
                if (hdr_pos < 4 && b != MAGIC_RLEF[hdr_pos[1:0]]) magic_bad = 1'b1;
                if (hdr_pos >= HDR_LEN - 1) begin
                    dec_phase = magic_bad ? PH_DISCARD : PH_IDLE;
                    hdr_pos   = 4'(HDR_LEN);
                    st        = magic_bad ? ST_BAD_MAGIC : ST_OK;
                end else begin
                    hdr_pos = hdr_pos + 4'd1;
                    st      = ST_SHORT;
                end
            end
            PH_IDLE: begin
                if (b == run_esc) dec_phase = PH_RUN_COUNT;
                else if (b == lit_esc) dec_phase = PH_LIT_COUNT;
                else step_q = {step_q, make_group(b, 4'd1)};
            end
            PH_RUN_COUNT: begin
                pend_cnt  = b;
                dec_phase = PH_RUN_VALUE;
            end
            PH_RUN_VALUE: begin
                remain = pend_cnt;
                while (remain > 0 && step_q.size() < MAX_GROUPS) begin
                    g = (remain > LANES) ? LANES : remain;
                    step_q = {step_q, make_group(b, 4'(g))};
                    remain -= g;
                end
                pend_cnt  = 8'd0;
                dec_phase = PH_IDLE;
            end
            PH_LIT_COUNT: begin
                pend_cnt  = b;
                dec_phase = (b != 8'd0) ? PH_LIT_DATA : PH_IDLE;
            end
            PH_LIT_DATA: begin
                step_q = {step_q, make_group(b, 4'd1)};
                pend_cnt = pend_cnt - 8'd1;
                if (pend_cnt == 8'd0) dec_phase = PH_IDLE;
            end
            PH_DISCARD: st = ST_BAD_MAGIC;
            default:    dec_phase = PH_IDLE;
        endcase

        // End of file: status rides on the last group, or on an empty one
        if (last) begin
            if (step_q.size() == 0) step_q = {step_q, make_group(8'h00, 4'd0)};
            tail = step_q.pop_back();
            tail.fend   = 1'b1;
            tail.status = st;
            step_q = {step_q, tail};
            clear_decoder();
        end
        if (step_q.size() != 0) begin
            tail = step_q.pop_back();
            tail.glast = 1'b1;
            step_q = {step_q, tail};
        end
    endfunction

    // Random file: mostly good header and records, some short or bad magic
    function automatic void make_random_file();
        int unsigned kind;
        int unsigned n;
        int unsigned bad_pos;
        int unsigned nrec;
        int unsigned cnt;
        file_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(1, HDR_LEN - 1);
            for (int i = 0; i < n; i++)
                file_q = {file_q, ((i < 4 && $urandom_range(0, 2) != 0) ?
                                   MAGIC_RLEF[i] : 8'($urandom_range(0, 255)))};
            return;
        end
        bad_pos = (kind == 1) ? $urandom_range(0, 3) : 4;
        for (int i = 0; i < 4; i++)
            file_q = {file_q, ((i == bad_pos) ?
                      (MAGIC_RLEF[i] ^ 8'(1 << $urandom_range(0, 7))) : MAGIC_RLEF[i])};
        for (int i = 0; i < 4; i++) file_q = {file_q, 8'($urandom_range(0, 255))};
        nrec = $urandom_range(0, 8);
        repeat (nrec) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: file_q = {file_q, 8'($urandom_range(0, 255))};
                4, 5, 6: begin
                    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 20);
                    file_q = {file_q, run_esc};
                    file_q = {file_q, 8'(cnt)};
                    file_q = {file_q, 8'($urandom_range(0, 255))};
                end
                default: begin
                    cnt = $urandom_range(0, 6);
                    file_q = {file_q, lit_esc};
                    file_q = {file_q, 8'(cnt)};
                    repeat (cnt) file_q = {file_q, 8'($urandom_range(0, 255))};
                end
            endcase
        end
        // Sometimes cut one or two bytes off the end of the file
        if (file_q.size() > HDR_LEN && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) void'(file_q.pop_back());
    endfunction

    // Offer one byte, predict on acceptance; returns at the following falling edge
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit typed, input t_group want);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        decode_byte(b, last);
        if (typed) exp_q = {exp_q, want};
        else exp_q = {exp_q, step_q};
        n_bytes++;
        @(negedge i_clk);
    endtask

    // Stop sending and let every expected group come out
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (exp_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write both escape registers back to back
    task automatic write_escapes(input logic [7:0] run_v, input logic [7:0] lit_v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_IDX_RUN_ESC;
        cfg_ch.data  <= run_v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        run_esc = run_v;
        @(negedge i_clk);
        cfg_ch.index <= CFG_IDX_LIT_ESC;
        cfg_ch.data  <= lit_v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        lit_esc = lit_v;
        n_cfg += 2;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic void cmp_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            err_cnt++;
        end
    endfunction

    // Output monitor: each accepted group against the oldest expectation
    always @(posedge i_clk) begin : group_check
        t_group got;
        t_group want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.lane[0] = out_ch.out_byte0;
            got.lane[1] = out_ch.out_byte1;
            got.lane[2] = out_ch.out_byte2;
            got.lane[3] = out_ch.out_byte3;
            got.lane[4] = out_ch.out_byte4;
            got.lane[5] = out_ch.out_byte5;
            got.lane[6] = out_ch.out_byte6;
            got.lane[7] = out_ch.out_byte7;
            got.nbytes  = out_ch.valid_bytes;
            got.glast   = out_ch.group_last;
            got.fend    = out_ch.file_end;
            got.status  = t_status'(out_ch.status);
            if (exp_q.size() == 0) begin
                $error("unexpected group: valid_bytes %0d file_end %0b",
                       got.nbytes, got.fend);
                err_cnt++;
            end else begin
                want = exp_q.pop_front();
                n_groups++;
                for (int j = 0; j < LANES; j++)
                    cmp_field($sformatf("out_byte%0d", j), want.lane[j], got.lane[j]);
                cmp_field("valid_bytes", want.nbytes, got.nbytes);
                cmp_field("group_last", want.glast, got.glast);
                cmp_field("file_end", want.fend, got.fend);
                cmp_field("status", want.status, got.status);
            end
        end
    end

    // Receiver: random stalls per group, one long hold-off on request
    initial begin : out_ready_gen
        int unsigned w;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
            end
            w = no_idle ? 0 : $urandom_range(0, 4);
            if (w != 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Stimulus
    initial begin : stimulus
        t_group      want;
        logic [7:0]  r_v;
        logic [7:0]  l_v;
        int unsigned items;
        int unsigned w;

        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.in_byte  = 8'h00;
        in_ch.in_last  = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = CFG_IDX_RUN_ESC;
        cfg_ch.data    = 8'h00;
        run_esc        = RUN_ESC_RST;
        lit_esc        = LIT_ESC_RST;
        clear_decoder();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed files at reset escapes; receiver opens with its long hold-off
        hold_req = 1'b1;
        for (int i = 0; i < DIR_ROWS; i++) begin
            want = make_group(dir_tab[i].value, dir_tab[i].nbytes);
            want.glast  = 1'b1;
            want.fend   = 1'b1;
            want.status = dir_tab[i].status;
            send_byte(dir_tab[i].data, dir_tab[i].last, dir_tab[i].typed, want);
        end
        n_files += 3;

        // Random files under several escape settings
        for (int s = 0; s < NUM_SETTINGS; s++) begin
            wait_idle();
            case (s)
                0:       begin r_v = RUN_ESC_RST; l_v = LIT_ESC_RST; end
                1:       begin r_v = 8'h00;       l_v = 8'hFF;       end
                2:       begin r_v = 8'hFF;       l_v = 8'h00;       end
                3:       begin r_v = 8'h55;       l_v = 8'h55;       end
                default: begin
                    r_v = 8'($urandom_range(0, 255));
                    l_v = 8'($urandom_range(0, 255));
                end
            endcase
            write_escapes(r_v, l_v);
            no_idle = (s == 2);
            items = 0;
            while (items < SETTING_ITEMS) begin
                make_random_file();
                foreach (file_q[j])
                    send_byte(file_q[j], j == file_q.size() - 1, 1'b0, '0);
                items += file_q.size();
                n_files++;
                if ($urandom_range(0, 7) == 0) wait_idle();
            end
        end
        in_ch.valid <= 1'b0;
        no_idle = 1'b0;

        // Drain, then settle for any stray group
        for (w = 0; w < 20000 && exp_q.size() != 0; w++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (exp_q.size() != 0) begin
            $error("%0d expected groups never arrived", exp_q.size());
            err_cnt++;
        end

        $display("Decoded %0d files (%0d input bytes), checked %0d output groups.",
                 n_files, n_bytes, n_groups);
        $display("Escape registers written %0d times, with idle, stall and drain gaps.",
                 n_cfg);
        if (err_cnt == 0) begin
            $display("rle_escape_stream_decoder regression: pass");
        end else begin
            $display("rle_escape_stream_decoder regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #5_000_000;
        $display("Watchdog expired with %0d groups outstanding.", exp_q.size());
        $display("rle_escape_stream_decoder regression: fail");
        $finish;
    end

endmodule
